// ===== sv/routing_neighbor_adjacency_fsm_top_defines.svh =====
// Assertion macros used by the checker file rna_checker.sv
`ifndef ROUTING_NEIGHBOR_ADJACENCY_FSM_TOP_DEFINES_SVH
`define ROUTING_NEIGHBOR_ADJACENCY_FSM_TOP_DEFINES_SVH

// same-cycle implication
`define RNA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RNA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/rna_pkg.sv =====
package rna_pkg;

   localparam int REQ_DATA_W  = 168;
   localparam int RSP_DATA_W  = 72;
   localparam int RSP_USER_W  = 2;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   typedef enum logic [1:0] {
      ST_DOWN    = 2'd0,
      ST_INIT    = 2'd1,
      ST_TWOWAY  = 2'd2,
      ST_EXSTART = 2'd3
   } nbr_state_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SEARCH,
      BK_FETCH,
      BK_UPDATE
   } back_state_type;

   typedef struct packed {
      logic [31:0] sender;
      logic [31:0] src;
      logic [31:0] dr;
      logic [31:0] bdr;
      logic        seen;
   } hello_type;

   typedef struct packed {
      logic full;
      logic nonempty;
   } queue_status_type;

endpackage

// ===== sv/rna_front.sv =====
module rna_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [31:0]                     csr_wr_data,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [rna_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            req_tuser,
   input  logic                            req_tlast,
   input  rna_pkg::queue_status_type       q_status,
   output logic                            q_push,
   output rna_pkg::hello_type              q_wdata
);
   import rna_pkg::*;

   logic [31:0] own_id_ff;
   logic        seen_ff;
   logic        seen_in;
   logic        accept;
   logic        self_hit;
   logic        seen_now;

   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;
   assign self_hit   = req_tuser && (req_tdata[167:136] == own_id_ff);
   assign seen_now   = seen_ff || self_hit;
   assign q_push     = accept && req_tlast;

   assign q_wdata.sender = req_tdata[31:0];
   assign q_wdata.src    = req_tdata[63:32];
   assign q_wdata.dr     = req_tdata[95:64];
   assign q_wdata.bdr    = req_tdata[127:96];
   assign q_wdata.seen   = seen_now;

   always_comb begin
      seen_in = seen_ff;
      if (accept) begin
         seen_in = req_tlast ? 1'b0 : seen_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff <= '0;
         seen_ff   <= 1'b0;
      end else begin
         seen_ff <= seen_in;
         if (csr_wr_en) begin
            own_id_ff <= csr_wr_data;
         end
      end
   end

endmodule

// ===== sv/rna_queue.sv =====
module rna_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  rna_pkg::hello_type        wdata,
   input  logic                      pop,
   output rna_pkg::hello_type        rdata,
   output rna_pkg::queue_status_type status
);
   import rna_pkg::*;

   hello_type              mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] cnt_ff;
   logic [QUEUE_CNT_W-1:0] cnt_in;
   logic                   do_push;
   logic                   do_pop;

   assign status.full     = (cnt_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign status.nonempty = (cnt_ff != '0);
   assign do_push         = push && !status.full;
   assign do_pop          = pop && status.nonempty;
   assign rdata           = mem_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

endmodule

// ===== sv/rna_back.sv =====
module rna_back #(
   parameter int MAX_NEIGHBORS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_valid,
   input  rna_pkg::hello_type              q_rdata,
   output logic                            q_pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [rna_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic [rna_pkg::RSP_USER_W-1:0]  rsp_tuser
);
   import rna_pkg::*;

   localparam int SLOT_W = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
   localparam int CNT_W  = $clog2(MAX_NEIGHBORS + 1);

   back_state_type      state_ff;
   back_state_type      state_in;
   hello_type           cur_ff;
   logic [31:0]         rid_ff [MAX_NEIGHBORS];
   nbr_state_type       state_mem [MAX_NEIGHBORS];
   nbr_state_type       rd_state_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic                hit_ff;
   logic                new_ff;
   logic                full_ff;
   logic [SLOT_W-1:0]   slot_ff;
   logic                rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_USER_W-1:0] rsp_user_ff;

   logic                match_hit;
   logic [SLOT_W-1:0]   match_slot;
   logic                out_free;
   logic                do_search;
   logic                do_fetch;
   logic                do_update;
   logic                room;
   nbr_state_type       old_st;
   nbr_state_type       new_st;
   nbr_state_type       out_st;
   logic [SLOT_W-1:0]   out_slot;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign room     = (cnt_ff < CNT_W'(MAX_NEIGHBORS));

   always_comb begin
      match_hit  = 1'b0;
      match_slot = '0;
      for (int i = MAX_NEIGHBORS - 1; i >= 0; i--) begin
         if ((CNT_W'(i) < cnt_ff) && (rid_ff[i] == cur_ff.sender)) begin
            match_hit  = 1'b1;
            match_slot = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE:   if (q_valid) state_in = BK_SEARCH;
         BK_SEARCH: state_in = BK_FETCH;
         BK_FETCH:  state_in = BK_UPDATE;
         BK_UPDATE: if (out_free) state_in = BK_IDLE;
         default:   state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      q_pop     = 1'b0;
      do_search = 1'b0;
      do_fetch  = 1'b0;
      do_update = 1'b0;
      unique case (state_ff)
         BK_IDLE:   q_pop     = q_valid;
         BK_SEARCH: do_search = 1'b1;
         BK_FETCH:  do_fetch  = 1'b1;
         BK_UPDATE: do_update = out_free;
         default:   q_pop     = 1'b0;
      endcase
   end

   always_comb begin
      old_st = new_ff ? ST_DOWN : rd_state_ff;
      new_st = (old_st == ST_DOWN) ? ST_INIT : old_st;
      if (cur_ff.seen) begin
         if (new_st == ST_INIT) begin
            new_st = ST_TWOWAY;
         end
      end else if (new_st == ST_TWOWAY) begin
         new_st = ST_INIT;
      end
      if (((cur_ff.dr == cur_ff.src) || (cur_ff.bdr == cur_ff.src)) &&
          (new_st == ST_TWOWAY)) begin
         new_st = ST_EXSTART;
      end
      out_st   = full_ff ? ST_DOWN : new_st;
      out_slot = full_ff ? '0 : slot_ff;
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_rdata;
      end
      if (do_search) begin
         hit_ff  <= match_hit;
         slot_ff <= match_slot;
      end
      if (do_fetch) begin
         new_ff  <= !hit_ff && room;
         full_ff <= !hit_ff && !room;
         if (!hit_ff && room) begin
            slot_ff                     <= cnt_ff[SLOT_W-1:0];
            rid_ff[cnt_ff[SLOT_W-1:0]]  <= cur_ff.sender;
         end
      end
      if (do_update) begin
         rsp_data_ff <= {3'b000, cur_ff.bdr, cur_ff.dr, out_st, 3'(out_slot)};
         rsp_user_ff <= {full_ff, new_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (do_fetch) begin
         rd_state_ff <= state_mem[slot_ff];
      end
      if (do_update && !full_ff) begin
         state_mem[slot_ff] <= new_st;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (do_fetch && !hit_ff && room) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (do_update) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== sv/routing_neighbor_adjacency_fsm_top.sv =====
// Each hello is queued, then the table engine pops it, searches, fetches the state,
// updates and registers the result on rsp_tvalid, taking no new hello until then.
// List transactions are taken 1 per cycle while req_tready is high. Two hellos may
// queue ahead of the table engine before req_tready drops.
// Reset clears the own id, the list flag, the queue, the entry count and rsp_tvalid;
// table contents are not cleared, entries past the count are never used.
module routing_neighbor_adjacency_fsm_top #(
   parameter int MAX_NEIGHBORS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [31:0]                     csr_wr_data,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // sender_rid, source_addr, adv_designated, adv_backup, sender_priority, listed_rid
   input  logic [rna_pkg::REQ_DATA_W-1:0]  req_tdata,
   // listed_valid
   input  logic                            req_tuser,
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // neighbor_slot, neighbor_state, current_designated, current_backup, zero pad
   output logic [rna_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // is_new, table_full
   output logic [rna_pkg::RSP_USER_W-1:0]  rsp_tuser
);
   import rna_pkg::*;

   queue_status_type q_status;
   logic             q_push;
   logic             q_pop;
   hello_type        q_wdata;
   hello_type        q_rdata;

   rna_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .q_status    (q_status),
      .q_push      (q_push),
      .q_wdata     (q_wdata)
   );

   rna_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wdata  (q_wdata),
      .pop    (q_pop),
      .rdata  (q_rdata),
      .status (q_status)
   );

   rna_back #(
      .MAX_NEIGHBORS (MAX_NEIGHBORS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_status.nonempty),
      .q_rdata    (q_rdata),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== sv/rna_checker.sv =====
`include "routing_neighbor_adjacency_fsm_top_defines.svh"

module rna_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [rna_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic [rna_pkg::RSP_USER_W-1:0]  rsp_tuser
);
   import rna_pkg::*;

   `RNA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "rsp_tvalid dropped while stalled")
   `RNA_ASSERT_NOW(a_full_fixed, clock, reset, rsp_tvalid && rsp_tuser[1], (rsp_tuser[0] == 1'b0) && (rsp_tdata[4:0] == 5'd0), "table full result not zeroed")
   `RNA_ASSERT_NOW(a_found_up, clock, reset, rsp_tvalid && !rsp_tuser[1], rsp_tdata[4:3] != ST_DOWN, "known neighbor reported down")
   `RNA_ASSERT_NOW(a_reset_idle, clock, 1'b0, $past(reset), !rsp_tvalid, "rsp_tvalid set right after reset")

endmodule

bind routing_neighbor_adjacency_fsm_top rna_checker u_rna_checker (.*);

// ===== dv/tb_routing_neighbor_adjacency_fsm_top.sv =====
module tb_routing_neighbor_adjacency_fsm_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rna_pkg::*;

   localparam int NBR_SLOTS   = 8;
   localparam int STALL_LIMIT = 4000;
   localparam int PHASE_ITEMS = 150;
   localparam logic [31:0] OWN_DIRECTED = 32'hC0A8_0001;

   typedef struct packed {
      logic [31:0] sender;
      logic [31:0] src;
      logic [31:0] dr;
      logic [31:0] bdr;
      logic [7:0]  prio;
      logic [31:0] listed;
      logic        valid;
      logic        last;
   } hello_item_type;

   typedef struct packed {
      logic [2:0]    slot;
      nbr_state_type state;
      logic          is_new;
      logic          full;
      logic [31:0]   dr;
      logic [31:0]   bdr;
   } adj_result_type;

   typedef struct {
      hello_item_type it;
      bit             fixed;
      adj_result_type res;
   } stim_row_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [31:0]            csr_wr_data;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic                   req_tuser;
   logic                   req_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [RSP_USER_W-1:0]  rsp_tuser;

   // predictor state
   logic [31:0]   own_rid_m;
   logic [31:0]   nbr_rid_m [NBR_SLOTS];
   nbr_state_type nbr_state_m [NBR_SLOTS];
   int            nbr_count_m;
   logic [31:0]   dr_m;
   logic [31:0]   bdr_m;
   bit            self_seen_m;

   adj_result_type pending_adj [$];
   stim_row_type   directed_rows [$];
   int             err_count;
   bit             burst_mode;

   routing_neighbor_adjacency_fsm_top #(
      .MAX_NEIGHBORS(NBR_SLOTS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic bit adjacency_predict(input hello_item_type it,
                                            output adj_result_type r);
      int            idx;
      bit            hit;
      nbr_state_type st;
      idx = 0;
      hit = 1'b0;
      r.slot   = '0;
      r.state  = ST_DOWN;
      r.is_new = 1'b0;
      r.full   = 1'b0;
      r.dr     = '0;
      r.bdr    = '0;
      if (it.valid && it.listed == own_rid_m)
         self_seen_m = 1'b1;
      if (!it.last)
         return 1'b0;
      for (int i = 0; i < nbr_count_m; i++) begin
         if (!hit && nbr_rid_m[i] == it.sender) begin
            idx = i;
            hit = 1'b1;
         end
      end
      if (!hit && nbr_count_m < NBR_SLOTS) begin
         idx = nbr_count_m;
         nbr_rid_m[idx]   = it.sender;
         nbr_state_m[idx] = ST_DOWN;
         nbr_count_m++;
         hit      = 1'b1;
         r.is_new = 1'b1;
      end else if (!hit) begin
         r.full = 1'b1;
      end
      dr_m  = it.dr;
      bdr_m = it.bdr;
      if (hit) begin
         st = nbr_state_m[idx];
         if (st == ST_DOWN)
            st = ST_INIT;
         if (self_seen_m) begin
            if (st == ST_INIT)
               st = ST_TWOWAY;
         end else if (st == ST_TWOWAY) begin
            st = ST_INIT;
         end
         if ((it.dr == it.src || it.bdr == it.src) && st == ST_TWOWAY)
            st = ST_EXSTART;
         nbr_state_m[idx] = st;
         r.slot  = idx[2:0];
         r.state = st;
      end
      self_seen_m = 1'b0;
      r.dr  = dr_m;
      r.bdr = bdr_m;
      return 1'b1;
   endfunction

   function automatic hello_item_type mk_item(input logic [31:0] sender, input logic [31:0] src,
                                              input logic [31:0] dr, input logic [31:0] bdr,
                                              input logic [7:0] prio, input logic [31:0] listed,
                                              input logic valid, input logic last);
      hello_item_type it;
      it.sender = sender;
      it.src    = src;
      it.dr     = dr;
      it.bdr    = bdr;
      it.prio   = prio;
      it.listed = listed;
      it.valid  = valid;
      it.last   = last;
      return it;
   endfunction

   function automatic adj_result_type mk_res(input logic [2:0] slot, input nbr_state_type state,
                                             input logic is_new, input logic full,
                                             input logic [31:0] dr, input logic [31:0] bdr);
      adj_result_type r;
      r.slot   = slot;
      r.state  = state;
      r.is_new = is_new;
      r.full   = full;
      r.dr     = dr;
      r.bdr    = bdr;
      return r;
   endfunction

   function automatic void add_row(input stim_row_type row);
      directed_rows = {directed_rows, row};
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 9))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_item(input hello_item_type it, input bit fixed,
                            input adj_result_type fixed_res);
      int             gap;
      adj_result_type r;
      gap = burst_mode ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {it.listed, it.prio, it.bdr, it.dr, it.src, it.sender};
      req_tuser  <= it.valid;
      req_tlast  <= it.last;
      do @(posedge clock); while (req_tready !== 1'b1);
      if (adjacency_predict(it, r))
         pending_adj = {pending_adj, (fixed ? fixed_res : r)};
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending_adj.size() != 0);
   endtask

   task automatic set_own_rid(input logic [31:0] v);
      wait_drained();
      repeat (12) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      own_rid_m = v;
   endtask

   // drive stimulus
   initial begin
      hello_item_type  it;
      adj_result_type  blank;
      logic [31:0]     own_vals [6];
      logic [31:0]     sender;
      logic [31:0]     src;
      logic [31:0]     dr;
      logic [31:0]     bdr;
      logic [7:0]      prio;
      int              len;
      int              own_pos;
      int              sent;
      bit              broken;

      reset       <= 1'b1;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= 1'b0;
      req_tlast   <= 1'b0;
      burst_mode  = 1'b0;
      err_count   = 0;
      own_rid_m   = '0;
      nbr_count_m = 0;
      dr_m        = '0;
      bdr_m       = '0;
      self_seen_m = 1'b0;
      blank = mk_res(3'd0, ST_DOWN, 1'b0, 1'b0, 32'h0, 32'h0);

      add_row('{mk_item(32'h0, 32'h0, 32'h0, 32'h0, 8'h00, 32'h0, 1'b0, 1'b1),
                1'b1, mk_res(3'd0, ST_INIT, 1'b1, 1'b0, 32'h0, 32'h0)});
      add_row('{mk_item(32'h0, 32'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF,
                        OWN_DIRECTED, 1'b1, 1'b1), 1'b0, blank});
      add_row('{mk_item(32'h0, 32'h5, 32'h5, 32'h7, 8'h01,
                        OWN_DIRECTED, 1'b1, 1'b1), 1'b0, blank});
      add_row('{mk_item(32'h0, 32'h5, 32'h9, 32'h9, 8'h01,
                        32'h0, 1'b0, 1'b1), 1'b0, blank});
      add_row('{mk_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1, 32'h2, 8'h80,
                        OWN_DIRECTED, 1'b0, 1'b0), 1'b0, blank});
      add_row('{mk_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1, 32'h2, 8'h80,
                        32'hFFFF_FFFF, 1'b1, 1'b0), 1'b0, blank});
      add_row('{mk_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1, 32'h2, 8'h80,
                        32'h0, 1'b1, 1'b1), 1'b0, blank});
      add_row('{mk_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h3, 32'h4, 8'h80,
                        OWN_DIRECTED, 1'b1, 1'b0), 1'b0, blank});
      add_row('{mk_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h3, 32'h4, 8'h80,
                        32'h1234_5678, 1'b1, 1'b1), 1'b0, blank});
      add_row('{mk_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h3, 32'h4, 8'h80,
                        32'h0, 1'b1, 1'b1), 1'b0, blank});
      add_row('{mk_item(32'hFFFF_FFFF, 32'h0A0A_0A0A, 32'h3, 32'h0A0A_0A0A,
                        8'h80, OWN_DIRECTED, 1'b1, 1'b1), 1'b0, blank});
      for (int s = 2; s < NBR_SLOTS; s++)
         add_row('{mk_item(s, s << 8, 32'h0, 32'h0, 8'(s * 37),
                           OWN_DIRECTED, s[0], 1'b1), 1'b0, blank});
      add_row('{mk_item(32'h0000_0064, 32'h0, 32'hAAAA_AAAA, 32'h5555_5555,
                        8'h00, OWN_DIRECTED, 1'b1, 1'b1),
                1'b1, mk_res(3'd0, ST_DOWN, 1'b0, 1'b1,
                             32'hAAAA_AAAA, 32'h5555_5555)});

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      set_own_rid(OWN_DIRECTED);
      foreach (directed_rows[i])
         send_item(directed_rows[i].it, directed_rows[i].fixed, directed_rows[i].res);

      own_vals[0] = 32'h0000_0000;
      own_vals[1] = 32'hFFFF_FFFF;
      own_vals[2] = $urandom;
      own_vals[3] = 32'h0000_0001;
      own_vals[4] = $urandom;
      own_vals[5] = 32'h8000_0000;

      for (int p = 0; p < 6; p++) begin
         set_own_rid(own_vals[p]);
         burst_mode = (p == 3);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            if ($urandom_range(0, 24) == 0)
               wait_drained();
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 5);
            if ($urandom_range(0, 99) < 85)
               sender = nbr_rid_m[$urandom_range(0, nbr_count_m - 1)];
            else
               sender = rand_word();
            src  = rand_word();
            prio = 8'($urandom_range(0, 255));
            case ($urandom_range(0, 59))
               0: begin dr = src;         bdr = rand_word(); end
               1: begin dr = rand_word(); bdr = src;         end
               default: begin dr = rand_word(); bdr = rand_word(); end
            endcase
            own_pos = $urandom_range(0, 1) ? $urandom_range(0, len - 1) : -1;
            broken  = ($urandom_range(0, 4) == 0);
            for (int k = 0; k < len; k++) begin
               if (broken && k != len - 1)
                  it = mk_item(rand_word(), rand_word(), rand_word(), rand_word(),
                               8'($urandom_range(0, 255)), 32'h0, 1'b0, 1'b0);
               else
                  it = mk_item(sender, src, dr, bdr, prio, 32'h0, 1'b0, 1'b0);
               it.listed = (k == own_pos) ? own_rid_m : rand_word();
               it.valid  = ($urandom_range(0, 6) != 0);
               it.last   = (k == len - 1);
               send_item(it, 1'b0, blank);
            end
            sent += len;
         end
      end

      wait_drained();
      repeat (20) @(negedge clock);
      if (err_count == 0 && pending_adj.size() == 0)
         $display("tb_routing_neighbor_adjacency_fsm_top: done, clean");
      else
         $display("tb_routing_neighbor_adjacency_fsm_top: done, errors");
      $finish;
   end

   // accept and check results
   initial begin
      adj_result_type got;
      adj_result_type exp;
      int             gap;
      rsp_tready <= 1'b0;
      @(negedge clock);
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         gap = burst_mode ? 0 : $urandom_range(0, 10);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         got.slot   = rsp_tdata[2:0];
         got.state  = nbr_state_type'(rsp_tdata[4:3]);
         got.dr     = rsp_tdata[36:5];
         got.bdr    = rsp_tdata[68:37];
         got.is_new = rsp_tuser[0];
         got.full   = rsp_tuser[1];
         if (pending_adj.size() == 0) begin
            err_count++;
            if (err_count <= 10)
               $display("unexpected transaction: slot %0d state %0d new %0b full %0b dr %h bdr %h",
                        got.slot, got.state, got.is_new, got.full, got.dr, got.bdr);
         end else begin
            exp = pending_adj.pop_front();
            if (got.slot !== exp.slot || got.state !== exp.state || got.is_new !== exp.is_new ||
                got.full !== exp.full || got.dr !== exp.dr || got.bdr !== exp.bdr) begin
               err_count++;
               if (err_count <= 10) begin
                  $display("mismatch exp: slot %0d state %0d new %0b full %0b dr %h bdr %h",
                           exp.slot, exp.state, exp.is_new, exp.full, exp.dr, exp.bdr);
                  $display("         got: slot %0d state %0d new %0b full %0b dr %h bdr %h",
                           got.slot, got.state, got.is_new, got.full, got.dr, got.bdr);
               end
            end
         end
         @(negedge clock);
      end
   end

   // stall watchdog
   initial begin
      int idle;
      idle = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid === 1'b1 && req_tready === 1'b1) ||
             (rsp_tvalid === 1'b1 && rsp_tready === 1'b1))
            idle = 0;
         else
            idle++;
         if (idle >= STALL_LIMIT) begin
            $display("tb_routing_neighbor_adjacency_fsm_top: done, errors");
            $finish;
         end
      end
   end

endmodule

// ===== routing_neighbor_adjacency_fsm_top.f =====
+incdir+sv
sv/rna_pkg.sv
sv/rna_front.sv
sv/rna_queue.sv
sv/rna_back.sv
sv/routing_neighbor_adjacency_fsm_top.sv
sv/rna_checker.sv
dv/tb_routing_neighbor_adjacency_fsm_top.sv
